@@ hdl/tci_pkg.sv @@
package tci_pkg;

    // Sizes
    localparam int STACK_DEPTH = 64;
    localparam int FRAC_BITS   = 16;
    localparam int ROT_FRAC    = 16;   // rotation registers are Q1.16
    localparam int COORD_W     = 32;
    localparam int ROT_W       = 18;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int POSE_W      = 4 * COORD_W;
    localparam int PROD_W      = ROT_W + COORD_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int SH_W        = SUM_W - ROT_FRAC;
    localparam int APB_ADDR_W  = 3;

    localparam longint ROT_HALF = longint'(1) << (ROT_FRAC - 1);

    localparam logic [COORD_W-1:0] DIR_X_RESET = COORD_W'(longint'(1) << FRAC_BITS);
    localparam logic [ROT_W-1:0]   COS_RESET   = ROT_W'(longint'(1) << ROT_FRAC);
    localparam logic [ROT_W-1:0]   SIN_RESET   = '0;

    // Command characters
    localparam logic [7:0] CH_DRAW     = 8'h46;  // 'F'
    localparam logic [7:0] CH_DRAW_ALT = 8'h47;  // 'G'
    localparam logic [7:0] CH_MOVE     = 8'h66;  // 'f'
    localparam logic [7:0] CH_LEFT     = 8'h2B;  // '+'
    localparam logic [7:0] CH_RIGHT    = 8'h2D;  // '-'
    localparam logic [7:0] CH_PUSH     = 8'h5B;  // '['
    localparam logic [7:0] CH_POP      = 8'h5D;  // ']'

    // Stack fault codes
    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_EMPTY = 2'd1;
    localparam logic [1:0] FAULT_FULL  = 2'd2;

    // Register select (paddr bit 2)
    localparam logic REG_COS = 1'b0;
    localparam logic REG_SIN = 1'b1;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_MOVE,
        OP_DRAW,
        OP_LEFT,
        OP_RIGHT,
        OP_PUSH,
        OP_POP,
        OP_RESTART
    } t_op;

    // Decoded item waiting for execution
    typedef struct packed {
        logic                vld;
        t_op                 op;
        logic [1:0]          fault;
        logic                fwd;     // pop right after push: pose is unchanged
        logic [ADDR_W-1:0]   addr;    // push slot
        logic [COORD_W-1:0]  sx;
        logic [COORD_W-1:0]  sy;
        logic [COORD_W-1:0]  sdx;
        logic [COORD_W-1:0]  sdy;
    } t_issue;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
    } t_pose;

endpackage

@@ hdl/tci_cmd_if.sv @@
interface tci_cmd_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [7:0]         command;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_dx;
    logic signed [31:0] start_dy;

    modport source (
        output valid, mode, command, start_x, start_y, start_dx, start_dy,
        input  ready
    );
    modport sink (
        input  valid, mode, command, start_x, start_y, start_dx, start_dy,
        output ready
    );
endinterface

@@ hdl/tci_vtx_if.sv @@
interface tci_vtx_if;
    logic               valid;
    logic               ready;
    logic               vertex_valid;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic [1:0]         stack_fault;

    modport source (
        output valid, vertex_valid, vertex_x, vertex_y, stack_fault,
        input  ready
    );
    modport sink (
        input  valid, vertex_valid, vertex_x, vertex_y, stack_fault,
        output ready
    );
endinterface

@@ hdl/tci_ram.sv @@
module tci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/tci_front.sv @@
module tci_front import tci_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tci_cmd_if.sink           i_cmd,
    input  logic              i_adv,
    output t_issue            o_issue,
    output logic              o_rd_en,
    output logic [ADDR_W-1:0] o_rd_addr,
    output logic [CNT_W-1:0]  o_count
);
    t_issue            r_s1, n_s1;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  cnt_dec;
    logic              acc;
    logic              push_ok, pop_ok;
    t_op               dec_op;
    logic [1:0]        dec_fault;

    // Stage is free when empty or moving on this cycle
    assign i_cmd.ready = !r_s1.vld || i_adv;
    assign acc         = i_cmd.valid && i_cmd.ready;
    assign push_ok     = r_cnt < CNT_W'(STACK_DEPTH);
    assign pop_ok      = r_cnt != '0;
    assign cnt_dec     = r_cnt - CNT_W'(1);

    // Command decode; stack bounds are settled here
    always_comb begin
        dec_op    = OP_NOP;
        dec_fault = FAULT_NONE;
        if (i_cmd.mode) begin
            dec_op = OP_RESTART;
        end else begin
            unique case (i_cmd.command) inside
                CH_DRAW, CH_DRAW_ALT: begin
                    dec_op = OP_DRAW;
                end
                CH_MOVE: begin
                    dec_op = OP_MOVE;
                end
                CH_LEFT: begin
                    dec_op = OP_LEFT;
                end
                CH_RIGHT: begin
                    dec_op = OP_RIGHT;
                end
                CH_PUSH: begin
                    if (push_ok) dec_op = OP_PUSH;
                    else         dec_fault = FAULT_FULL;
                end
                CH_POP: begin
                    if (pop_ok) dec_op = OP_POP;
                    else        dec_fault = FAULT_EMPTY;
                end
                default: begin
                    dec_op = OP_NOP;
                end
            endcase
        end
    end

    // Stage register and stack depth counter
    always_comb begin
        n_s1  = r_s1;
        n_cnt = r_cnt;
        if (acc) begin
            n_s1.vld   = 1'b1;
            n_s1.op    = dec_op;
            n_s1.fault = dec_fault;
            n_s1.fwd   = i_adv && (r_s1.op == OP_PUSH) && (dec_op == OP_POP);
            n_s1.addr  = r_cnt[ADDR_W-1:0];
            n_s1.sx    = i_cmd.start_x;
            n_s1.sy    = i_cmd.start_y;
            n_s1.sdx   = i_cmd.start_dx;
            n_s1.sdy   = i_cmd.start_dy;
            case (dec_op)
                OP_RESTART: n_cnt = '0;
                OP_PUSH:    n_cnt = r_cnt + CNT_W'(1);
                OP_POP:     n_cnt = cnt_dec;
                default:    n_cnt = r_cnt;
            endcase
        end else if (i_adv) begin
            n_s1.vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_s1  <= n_s1;
            r_cnt <= n_cnt;
        end
    end

    // Pop reads the top entry as the item enters
    assign o_rd_en   = acc && (dec_op == OP_POP);
    assign o_rd_addr = cnt_dec[ADDR_W-1:0];
    assign o_issue   = r_s1;
    assign o_count   = r_cnt;
endmodule

@@ hdl/tci_pose.sv @@
module tci_pose import tci_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_issue                  i_issue,
    input  logic signed [ROT_W-1:0] i_rot_cos,
    input  logic signed [ROT_W-1:0] i_rot_sin,
    input  logic [POSE_W-1:0]       i_rd_data,
    output logic                    o_adv,
    output logic                    o_wr_en,
    output logic [ADDR_W-1:0]       o_wr_addr,
    output logic [POSE_W-1:0]       o_wr_data,
    tci_vtx_if.source               o_vtx
);
    t_pose               r_pose, n_pose;
    t_pose               pop_pose;
    logic                r_ovld;
    logic                r_vv, n_vv;
    logic [COORD_W-1:0]  r_x, r_y;
    logic [1:0]          r_fault;
    logic                out_free;

    logic signed [PROD_W-1:0] p_cdx, p_cdy, p_sdx, p_sdy;
    logic signed [SUM_W-1:0]  nx_sum, ny_sum, nx_rnd, ny_rnd;
    logic signed [SH_W-1:0]   mx_sum, my_sum;
    logic                     left;

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [SH_W-1:0] v);
        logic [SH_W-COORD_W:0] top;
        top = v[SH_W-1:COORD_W-1];
        if (top == '0 || top == '1) return v[COORD_W-1:0];
        else if (v[SH_W-1])         return {1'b1, {(COORD_W-1){1'b0}}};
        else                        return {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

    assign out_free = !r_ovld || o_vtx.ready;
    assign o_adv    = i_issue.vld && out_free;
    assign left     = i_issue.op == OP_LEFT;

    // Rotation: four products, signed sums, round half up
    assign p_cdx  = i_rot_cos * $signed(r_pose.dx);
    assign p_cdy  = i_rot_cos * $signed(r_pose.dy);
    assign p_sdx  = i_rot_sin * $signed(r_pose.dx);
    assign p_sdy  = i_rot_sin * $signed(r_pose.dy);
    assign nx_sum = left ? SUM_W'(p_cdx) - SUM_W'(p_sdy) : SUM_W'(p_cdx) + SUM_W'(p_sdy);
    assign ny_sum = left ? SUM_W'(p_cdy) + SUM_W'(p_sdx) : SUM_W'(p_cdy) - SUM_W'(p_sdx);
    assign nx_rnd = nx_sum + SUM_W'(ROT_HALF);
    assign ny_rnd = ny_sum + SUM_W'(ROT_HALF);

    // Movement sums, widened so the same saturation applies
    assign mx_sum = SH_W'($signed(r_pose.x)) + SH_W'($signed(r_pose.dx));
    assign my_sum = SH_W'($signed(r_pose.y)) + SH_W'($signed(r_pose.dy));

    // Pop right after a push gets back the pose just stored
    assign pop_pose = i_issue.fwd ? r_pose : t_pose'(i_rd_data);

    always_comb begin
        n_pose = r_pose;
        n_vv   = 1'b0;
        case (i_issue.op)
            OP_RESTART: begin
                n_pose = '{x: i_issue.sx, y: i_issue.sy, dx: i_issue.sdx, dy: i_issue.sdy};
                n_vv   = 1'b1;
            end
            OP_DRAW: begin
                n_pose.x = sat_coord(mx_sum);
                n_pose.y = sat_coord(my_sum);
                n_vv     = 1'b1;
            end
            OP_MOVE: begin
                n_pose.x = sat_coord(mx_sum);
                n_pose.y = sat_coord(my_sum);
            end
            OP_LEFT, OP_RIGHT: begin
                n_pose.dx = sat_coord(nx_rnd[SUM_W-1:ROT_FRAC]);
                n_pose.dy = sat_coord(ny_rnd[SUM_W-1:ROT_FRAC]);
            end
            OP_POP: begin
                n_pose = pop_pose;
            end
            default: begin
                n_pose = r_pose;
            end
        endcase
    end

    // Pose and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose <= '{x: '0, y: '0, dx: DIR_X_RESET, dy: '0};
            r_ovld <= 1'b0;
        end else if (o_adv) begin
            r_pose <= n_pose;
            r_ovld <= 1'b1;
        end else if (o_vtx.ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_vv    <= n_vv;
            r_x     <= n_pose.x;
            r_y     <= n_pose.y;
            r_fault <= i_issue.fault;
        end
    end

    // Push stores the current pose
    assign o_wr_en   = o_adv && (i_issue.op == OP_PUSH);
    assign o_wr_addr = i_issue.addr;
    assign o_wr_data = r_pose;

    assign o_vtx.valid        = r_ovld;
    assign o_vtx.vertex_valid = r_vv;
    assign o_vtx.vertex_x     = r_x;
    assign o_vtx.vertex_y     = r_y;
    assign o_vtx.stack_fault  = r_fault;
endmodule

@@ hdl/turtle_command_interpreter_top.sv @@
// Pipeline: an accepted item passes the decode register, then the output register;
// both hold their item while the output is not taken.
// Throughput: one item per cycle while results are taken, set by the pose register
// loop through the rotation multiply-add and the stack memory read (issued at accept).
// Reset: synchronous, active low. Pose goes to (0,0) heading (1,0), stack empty,
// rotation cos = 1.0 and sin = 0. Stack memory contents are not cleared.
module turtle_command_interpreter_top import tci_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tci_cmd_if.sink               i_cmd,
    tci_vtx_if.source             o_vtx,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    logic signed [ROT_W-1:0] r_rot_cos, r_rot_sin;
    logic                    cfg_wr;
    t_issue                  issue;
    logic                    adv;
    logic                    rd_en, wr_en;
    logic [ADDR_W-1:0]       rd_addr, wr_addr;
    logic [POSE_W-1:0]       rd_data, wr_data;
    logic [CNT_W-1:0]        count;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_cos <= COS_RESET;
            r_rot_sin <= SIN_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_SIN) r_rot_sin <= pwdata[ROT_W-1:0];
            else                     r_rot_cos <= pwdata[ROT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_SIN) ? 32'(r_rot_sin) : 32'(r_rot_cos);

    tci_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .i_adv     (adv),
        .o_issue   (issue),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .o_count   (count)
    );

    tci_ram #(
        .WIDTH (POSE_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    tci_pose u_pose (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_issue   (issue),
        .i_rot_cos (r_rot_cos),
        .i_rot_sin (r_rot_sin),
        .i_rd_data (rd_data),
        .o_adv     (adv),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_vtx     (o_vtx)
    );

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CNT_W'(STACK_DEPTH))
        else $error("stack count above depth");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready && i_cmd.mode) |=> (count == '0))
        else $error("restart did not clear stack");

    a_collision_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en && (wr_addr == rd_addr)) |=> (issue.vld && issue.fwd))
        else $error("read-during-write on stack not forwarded");

    a_fwd_only_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue.vld && issue.fwd) |-> (issue.op == OP_POP))
        else $error("forward flag on non-pop item");
endmodule
